FILE: hw/rtl/aasc_pkg.sv
// Package for the ADC averaging to servo compare block: payload types,
// field widths and the fixed scaling constants. Depends on nothing.
`default_nettype none

package aasc_pkg;

    // Field widths of the input and result transactions.
    localparam int unsigned SAMPLE_W   = 10;
    localparam int unsigned CHAN_W     = 2;
    localparam int unsigned FILTERED_W = 10;
    localparam int unsigned WIDE_W     = 13;
    localparam int unsigned NARROW_W   = 6;

    localparam int unsigned NUM_CHAN = 4;

    // Channels that feed each compare value.
    localparam int unsigned WIDE_A_CHAN   = 3;
    localparam int unsigned WIDE_B_CHAN   = 2;
    localparam int unsigned NARROW_A_CHAN = 1;
    localparam int unsigned NARROW_B_CHAN = 0;

    // Compare value scaling: base + avg * gain / SCALE_DIV.
    localparam int unsigned WIDE_BASE   = 2000;
    localparam int unsigned WIDE_GAIN   = 3250;
    localparam int unsigned NARROW_BASE = 20;
    localparam int unsigned NARROW_GAIN = 35;
    localparam int unsigned NARROW_MAX  = 55;
    localparam int unsigned SCALE_DIV   = 1023;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
    } sample_t;

    typedef struct packed {
        logic [CHAN_W-1:0]     channel;
        logic [FILTERED_W-1:0] filtered;
        logic [WIDE_W-1:0]     wide_a;
        logic [WIDE_W-1:0]     wide_b;
        logic [NARROW_W-1:0]   narrow_a;
        logic [NARROW_W-1:0]   narrow_b;
    } result_t;

    // Load strobes for the two register stages of the scaling datapath.
    typedef struct packed {
        logic load_prod;
        logic load_out;
    } scale_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/aasc_stream_if.sv
// Valid/ready stream interface used for both channels of the block.
// The payload type is a parameter; the block uses types from aasc_pkg.
`default_nettype none

interface aasc_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );

endinterface

`default_nettype wire

FILE: hw/rtl/aasc_servo_scale.sv
// Two-stage datapath that turns the four channel averages into servo
// compare values. Depends on aasc_pkg for the scaling constants and widths.
`default_nettype none

module aasc_servo_scale #(
    parameter int SAMPLE_BITS = 10
) (
    input  wire                                                   clk,
    input  aasc_pkg::scale_ctrl_t                                 ctrl,
    input  wire [aasc_pkg::NUM_CHAN-1:0][SAMPLE_BITS-1:0]          averages,
    output logic [aasc_pkg::WIDE_W-1:0]                           wide_a,
    output logic [aasc_pkg::WIDE_W-1:0]                           wide_b,
    output logic [aasc_pkg::NARROW_W-1:0]                         narrow_a,
    output logic [aasc_pkg::NARROW_W-1:0]                         narrow_b
);

    // Product widths follow from the gains.
    localparam int WP_W  = SAMPLE_BITS + $clog2(aasc_pkg::WIDE_GAIN + 1);
    localparam int NP_W  = SAMPLE_BITS + $clog2(aasc_pkg::NARROW_GAIN + 1);
    localparam int DIV_W = $clog2(aasc_pkg::SCALE_DIV + 1);

    // Division by SCALE_DIV is a multiply by a rounded-up reciprocal. With the
    // shift set to the dividend width plus the divisor width it is exact.
    localparam int W_K = WP_W + DIV_W;
    localparam int N_K = NP_W + DIV_W;
    localparam logic [63:0] W_RECIP_L =
        ((64'd1 << W_K) + 64'(aasc_pkg::SCALE_DIV) - 64'd1) / 64'(aasc_pkg::SCALE_DIV);
    localparam logic [63:0] N_RECIP_L =
        ((64'd1 << N_K) + 64'(aasc_pkg::SCALE_DIV) - 64'd1) / 64'(aasc_pkg::SCALE_DIV);
    localparam logic [WP_W:0] W_RECIP = W_RECIP_L[WP_W:0];
    localparam logic [NP_W:0] N_RECIP = N_RECIP_L[NP_W:0];

    localparam logic [SAMPLE_BITS-1:0] NARROW_SPAN =
        SAMPLE_BITS'(aasc_pkg::NARROW_MAX - aasc_pkg::NARROW_BASE);

    logic [WP_W-1:0] wprod_a_reg;
    logic [WP_W-1:0] wprod_b_reg;
    logic [NP_W-1:0] nprod_a_reg;
    logic [NP_W-1:0] nprod_b_reg;

    logic [2*WP_W:0] wq_a_full;
    logic [2*WP_W:0] wq_b_full;
    logic [2*NP_W:0] nq_a_full;
    logic [2*NP_W:0] nq_b_full;

    logic [aasc_pkg::WIDE_W-1:0]   wide_a_next;
    logic [aasc_pkg::WIDE_W-1:0]   wide_b_next;
    logic [SAMPLE_BITS-1:0]        nq_a;
    logic [SAMPLE_BITS-1:0]        nq_b;
    logic [aasc_pkg::NARROW_W-1:0] narrow_a_next;
    logic [aasc_pkg::NARROW_W-1:0] narrow_b_next;

    // Stage one: gain products.
    always_ff @(posedge clk)
    begin
        if (ctrl.load_prod)
        begin
            wprod_a_reg <= WP_W'(averages[aasc_pkg::WIDE_A_CHAN])
                         * WP_W'(aasc_pkg::WIDE_GAIN);
            wprod_b_reg <= WP_W'(averages[aasc_pkg::WIDE_B_CHAN])
                         * WP_W'(aasc_pkg::WIDE_GAIN);
            nprod_a_reg <= NP_W'(averages[aasc_pkg::NARROW_A_CHAN])
                         * NP_W'(aasc_pkg::NARROW_GAIN);
            nprod_b_reg <= NP_W'(averages[aasc_pkg::NARROW_B_CHAN])
                         * NP_W'(aasc_pkg::NARROW_GAIN);
        end
    end

    // Stage two: reciprocal multiply, offset and clamp.
    assign wq_a_full = (2*WP_W+1)'(wprod_a_reg) * (2*WP_W+1)'(W_RECIP);
    assign wq_b_full = (2*WP_W+1)'(wprod_b_reg) * (2*WP_W+1)'(W_RECIP);
    assign nq_a_full = (2*NP_W+1)'(nprod_a_reg) * (2*NP_W+1)'(N_RECIP);
    assign nq_b_full = (2*NP_W+1)'(nprod_b_reg) * (2*NP_W+1)'(N_RECIP);

    // The wide value wraps to its field width when the quotient is too large.
    assign wide_a_next = aasc_pkg::WIDE_W'(wq_a_full >> W_K)
                       + aasc_pkg::WIDE_W'(aasc_pkg::WIDE_BASE);
    assign wide_b_next = aasc_pkg::WIDE_W'(wq_b_full >> W_K)
                       + aasc_pkg::WIDE_W'(aasc_pkg::WIDE_BASE);

    // The narrow quotient does not exceed the average itself, so it fits its width.
    assign nq_a = SAMPLE_BITS'(nq_a_full >> N_K);
    assign nq_b = SAMPLE_BITS'(nq_b_full >> N_K);

    function automatic logic [aasc_pkg::NARROW_W-1:0] narrow_clamp(
        input logic [SAMPLE_BITS-1:0] q
    );
        if (q > NARROW_SPAN)
        begin
            narrow_clamp = aasc_pkg::NARROW_W'(aasc_pkg::NARROW_MAX);
        end
        else
        begin
            narrow_clamp = aasc_pkg::NARROW_W'(aasc_pkg::NARROW_BASE)
                         + aasc_pkg::NARROW_W'(q);
        end
    endfunction

    assign narrow_a_next = narrow_clamp(nq_a);
    assign narrow_b_next = narrow_clamp(nq_b);

    always_ff @(posedge clk)
    begin
        if (ctrl.load_out)
        begin
            wide_a   <= wide_a_next;
            wide_b   <= wide_b_next;
            narrow_a <= narrow_a_next;
            narrow_b <= narrow_b_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/adc_average_to_servo_compare.sv
// Top level of the four-channel ADC moving average with servo compare outputs.
// Depends on aasc_pkg, aasc_stream_if and aasc_servo_scale.
//
// Each sample transaction on adc is filed under the next channel of a
// rotating 0..3 counter and written into that channel's TAPS-entry history
// at the slot named by one slot counter shared by all channels. The history
// row is averaged (sum divided by TAPS, truncating) and becomes the channel's
// stored average. Every sample then yields exactly one result transaction on
// servo carrying the channel, its new average and four compare values built
// from the stored averages of all channels: wide values 2000 + avg*3250/1023
// from channels 3 and 2, and narrow values 20 + avg*35/1023 clamped to 20..55
// from channels 1 and 0. The block is a five-stage pipeline (input register,
// history sum, average, gain products, compare values) and takes one sample
// transaction per clock; each sample passes through the stages in that order
// before its result is presented on servo. The whole pipeline holds while a
// result waits on servo.ready, so throughput is one per clock whenever the
// sink takes results every cycle.
// History and averages are cleared to zero by reset, so unused channels give
// compare values of 2000 and 20.
`default_nettype none

module adc_average_to_servo_compare #(
    parameter int TAPS        = 3,
    parameter int SAMPLE_BITS = 10
) (
    input  wire          clk,
    input  wire          rst_n,
    aasc_stream_if.sink   adc,
    aasc_stream_if.source servo
);

    localparam int SLOT_W = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int SUM_W  = SAMPLE_BITS + $clog2(TAPS);

    // Sum divided by TAPS as a multiply by a rounded-up reciprocal. Three extra
    // shift bits cover any TAPS up to eight exactly.
    localparam int AVG_K = SUM_W + 3;
    localparam logic [63:0] AVG_RECIP_L = ((64'd1 << AVG_K) + 64'(TAPS) - 64'd1) / 64'(TAPS);
    localparam logic [AVG_K:0] AVG_RECIP = AVG_RECIP_L[AVG_K:0];

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TAPS - 1);

    // Pipeline advance: every stage moves when the result register is free
    // or its result is being taken this cycle.
    logic advance;

    // Channel and slot counters.
    logic [aasc_pkg::CHAN_W-1:0] chan_reg;
    logic [SLOT_W-1:0]           slot_reg;

    // Stage 1: input register.
    logic                        in_valid_reg;
    logic [SAMPLE_BITS-1:0]      in_sample_reg;
    logic [aasc_pkg::CHAN_W-1:0] in_chan_reg;
    logic [SLOT_W-1:0]           in_slot_reg;

    // Stage 2: history write and row sum.
    logic [aasc_pkg::NUM_CHAN-1:0][TAPS-1:0][SAMPLE_BITS-1:0] history_reg;
    logic [TAPS-1:0][SAMPLE_BITS-1:0] row_next;
    logic [SUM_W-1:0]                 sum_next;
    logic                             sum_valid_reg;
    logic [SUM_W-1:0]                 sum_reg;
    logic [aasc_pkg::CHAN_W-1:0]      sum_chan_reg;

    // Stage 3: average.
    logic [SUM_W+AVG_K:0]                              avg_prod;
    logic [SAMPLE_BITS-1:0]                            avg_q;
    logic [aasc_pkg::NUM_CHAN-1:0][SAMPLE_BITS-1:0]    averages_reg;
    logic                                              avg_valid_reg;
    logic [aasc_pkg::CHAN_W-1:0]                       avg_chan_reg;
    logic [aasc_pkg::FILTERED_W-1:0]                   avg_filt_reg;

    // Stage 4: gain products (inside the scaler).
    logic                            prod_valid_reg;
    logic [aasc_pkg::CHAN_W-1:0]     prod_chan_reg;
    logic [aasc_pkg::FILTERED_W-1:0] prod_filt_reg;

    // Stage 5: result register.
    logic                            out_valid_reg;
    logic [aasc_pkg::CHAN_W-1:0]     out_chan_reg;
    logic [aasc_pkg::FILTERED_W-1:0] out_filt_reg;

    aasc_pkg::scale_ctrl_t scale_ctrl;

    assign advance   = !out_valid_reg || servo.ready;
    assign adc.ready = advance;

    // New history row with this sample in its slot, and the row sum.
    always_comb
    begin
        row_next = history_reg[in_chan_reg];
        row_next[in_slot_reg] = in_sample_reg;
        sum_next = '0;
        for (int i = 0; i < TAPS; i++)
        begin
            sum_next = sum_next + SUM_W'(row_next[i]);
        end
    end

    assign avg_prod = (SUM_W+AVG_K+1)'(sum_reg) * (SUM_W+AVG_K+1)'(AVG_RECIP);
    assign avg_q    = avg_prod[AVG_K +: SAMPLE_BITS];

    // Control state and filter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg       <= '0;
            slot_reg       <= '0;
            in_valid_reg   <= 1'b0;
            sum_valid_reg  <= 1'b0;
            avg_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            history_reg    <= '0;
            averages_reg   <= '0;
        end
        else if (advance)
        begin
            in_valid_reg   <= adc.valid;
            sum_valid_reg  <= in_valid_reg;
            avg_valid_reg  <= sum_valid_reg;
            prod_valid_reg <= avg_valid_reg;
            out_valid_reg  <= prod_valid_reg;
            if (adc.valid)
            begin
                chan_reg <= chan_reg + 1'b1;
                slot_reg <= (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
            end
            if (in_valid_reg)
            begin
                history_reg[in_chan_reg] <= row_next;
            end
            if (sum_valid_reg)
            begin
                averages_reg[sum_chan_reg] <= avg_q;
            end
        end
    end

    // Payload registers along the pipeline.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (adc.valid)
            begin
                in_sample_reg <= SAMPLE_BITS'(adc.data.sample);
                in_chan_reg   <= chan_reg;
                in_slot_reg   <= slot_reg;
            end
            if (in_valid_reg)
            begin
                sum_reg      <= sum_next;
                sum_chan_reg <= in_chan_reg;
            end
            if (sum_valid_reg)
            begin
                avg_chan_reg <= sum_chan_reg;
                avg_filt_reg <= aasc_pkg::FILTERED_W'(avg_q);
            end
            if (avg_valid_reg)
            begin
                prod_chan_reg <= avg_chan_reg;
                prod_filt_reg <= avg_filt_reg;
            end
            if (prod_valid_reg)
            begin
                out_chan_reg <= prod_chan_reg;
                out_filt_reg <= prod_filt_reg;
            end
        end
    end

    // The averages register holds the state after the item in the average
    // stage, and it changes only when that item moves on, so the scaler reads
    // it directly.
    assign scale_ctrl.load_prod = advance && avg_valid_reg;
    assign scale_ctrl.load_out  = advance && prod_valid_reg;

    aasc_servo_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .clk      (clk),
        .ctrl     (scale_ctrl),
        .averages (averages_reg),
        .wide_a   (servo.data.wide_a),
        .wide_b   (servo.data.wide_b),
        .narrow_a (servo.data.narrow_a),
        .narrow_b (servo.data.narrow_b)
    );

    assign servo.valid         = out_valid_reg;
    assign servo.data.channel  = out_chan_reg;
    assign servo.data.filtered = out_filt_reg;

endmodule

`default_nettype wire

FILE: sim/adc_average_to_servo_compare_test.sv
// Self-checking testbench for adc_average_to_servo_compare: a scoreboard class
// predicts every servo result from the accepted samples and checks it in order.
// Depends on aasc_pkg, aasc_stream_if and the block's RTL.
`timescale 1ns / 100ps

module adc_average_to_servo_compare_test;

    // Depth of each channel's history; the block is built with the same value.
    localparam int HIST_DEPTH = 3;
    localparam int CHANNELS   = 4;

    // Scaling of the servo compare values, kept apart from the RTL's package.
    localparam int unsigned PULSE_WIDE_BASE   = 2000;
    localparam int unsigned PULSE_WIDE_GAIN   = 3250;
    localparam int unsigned PULSE_NARROW_BASE = 20;
    localparam int unsigned PULSE_NARROW_GAIN = 35;
    localparam int unsigned PULSE_NARROW_TOP  = 55;
    localparam int unsigned FULL_SCALE        = 1023;

    localparam logic [9:0] SAMPLE_MAX = 10'h3FF;

    // Long receiver hold-off that lets the pipeline fill and stall its input.
    localparam int HOLD_OFF_CYCLES = 300;

    // Holds a private copy of the filter state and the queue of results that
    // the block still owes. Samples are noted at the edge where their
    // transaction is accepted and results are checked in order of arrival.
    class servo_scoreboard;
        logic [9:0]         history [CHANNELS][HIST_DEPTH];
        logic [9:0]         averages [CHANNELS];
        int unsigned        next_chan;
        int unsigned        next_slot;
        aasc_pkg::result_t  owed_results [$];
        int unsigned        errors;

        function new();
            next_chan = 0;
            next_slot = 0;
            errors    = 0;
            foreach (averages[c])
            begin
                averages[c] = '0;
                foreach (history[c][s])
                    history[c][s] = '0;
            end
        endfunction

        function logic [12:0] wide_pulse(input logic [9:0] avg);
            int unsigned v;
            v = PULSE_WIDE_BASE + (avg * PULSE_WIDE_GAIN) / FULL_SCALE;
            return v[12:0];
        endfunction

        function logic [5:0] narrow_pulse(input logic [9:0] avg);
            int unsigned v;
            v = PULSE_NARROW_BASE + (avg * PULSE_NARROW_GAIN) / FULL_SCALE;
            if (v < PULSE_NARROW_BASE)
                v = PULSE_NARROW_BASE;
            if (v > PULSE_NARROW_TOP)
                v = PULSE_NARROW_TOP;
            return v[5:0];
        endfunction

        // The slot pointer is shared by all channels, so a channel's write
        // lands wherever the pointer happens to stand.
        function void note_sample(input logic [9:0] sample);
            int unsigned        sum;
            aasc_pkg::result_t  r;
            history[next_chan][next_slot] = sample;
            next_slot = (next_slot + 1) % HIST_DEPTH;
            sum = 0;
            for (int i = 0; i < HIST_DEPTH; i++)
                sum += history[next_chan][i];
            averages[next_chan] = 10'(sum / HIST_DEPTH);
            r.channel  = next_chan[1:0];
            r.filtered = averages[next_chan];
            r.wide_a   = wide_pulse(averages[3]);
            r.wide_b   = wide_pulse(averages[2]);
            r.narrow_a = narrow_pulse(averages[1]);
            r.narrow_b = narrow_pulse(averages[0]);
            owed_results.push_back(r);
            next_chan = (next_chan + 1) % CHANNELS;
        endfunction

        function void compare_field(input string name, input int unsigned want,
                                    input int unsigned got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(input aasc_pkg::result_t got);
            aasc_pkg::result_t want;
            if (owed_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                return;
            end
            want = owed_results.pop_front();
            compare_field("channel",  want.channel,  got.channel);
            compare_field("filtered", want.filtered, got.filtered);
            compare_field("wide_a",   want.wide_a,   got.wide_a);
            compare_field("wide_b",   want.wide_b,   got.wide_b);
            compare_field("narrow_a", want.narrow_a, got.narrow_a);
            compare_field("narrow_b", want.narrow_b, got.narrow_b);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    aasc_stream_if #(.payload_t(aasc_pkg::sample_t)) adc_if ();
    aasc_stream_if #(.payload_t(aasc_pkg::result_t)) servo_if ();

    adc_average_to_servo_compare #(
        .TAPS        (HIST_DEPTH),
        .SAMPLE_BITS (10)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .adc   (adc_if),
        .servo (servo_if)
    );

    servo_scoreboard scoreboard = new();

    // Chance, in percent, that the sample source idles or that the servo
    // sink stalls in a given cycle. The stimulus changes them per phase.
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;

    // Raised by the stimulus to ask the sink for one long hold-off.
    bit hold_request = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Reset is asserted from time zero, then released and never asserted again.
    initial
    begin
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Sends one sample transaction. A random gap is placed in front of it
    // according to idle_pct. Valid is only lowered when a gap follows, so a
    // back-to-back transaction never sees valid dropped and raised in one step.
    // The handshake is sampled right after the edge, before any update from
    // that edge lands, so it reflects what the block saw at the edge.
    task automatic send_sample(input logic [9:0] value);
        int unsigned        gap;
        aasc_pkg::sample_t  s;
        gap = 0;
        while ($urandom_range(99) < idle_pct && gap < 200)
            gap++;
        if (gap != 0)
        begin
            adc_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s.sample = value;
        adc_if.valid <= 1'b1;
        adc_if.data  <= s;
        @(posedge clk);
        while (!adc_if.ready)
            @(posedge clk);
        scoreboard.note_sample(value);
    endtask

    // Servo sink: checks each accepted result transaction and chooses ready
    // for the next cycle. A hold-off request keeps ready low for a long,
    // self-counted stretch so the block backs up all the way to its input.
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        servo_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (servo_if.valid === 1'b1 && servo_if.ready === 1'b1)
                scoreboard.check_result(servo_if.data);
            if (hold_request)
            begin
                hold_left    = HOLD_OFF_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                servo_if.ready <= 1'b0;
            end
            else
                servo_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Stimulus: a directed opening, four random phases with different
    // idling and stalling, a pressure phase, then a drain and the verdict.
    initial
    begin
        logic [9:0] value;
        adc_if.valid <= 1'b0;
        adc_if.data  <= '0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);

        // Straight after reset the channels not yet sampled still hold
        // zero averages, so their compare values sit at the base values.
        for (int i = 1; i <= 4; i++)
            send_sample(i[9:0]);

        // Twelve full-scale samples fill every slot of every channel, since
        // the shared slot pointer walks all three slots of each channel.
        repeat (12)
            send_sample(SAMPLE_MAX);

        send_sample(10'h2AA);
        send_sample(10'h155);
        send_sample(10'h200);
        send_sample(10'h001);
        send_sample(SAMPLE_MAX);
        send_sample(10'h000);

        // Random phases: no idling, sparse source, slow sink, light idling.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 88;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 88;
                end
                default:
                begin
                    idle_pct  = 8;
                    stall_pct = 8;
                end
            endcase
            repeat (190)
            begin
                case ($urandom_range(3))
                    0: value = $urandom_range(1) ? SAMPLE_MAX : 10'h000;
                    1: value = 10'($urandom_range(15));
                    default: value = 10'($urandom_range(SAMPLE_MAX));
                endcase
                send_sample(value);
            end
        end

        // Pressure: the sink holds off for a long stretch while the source
        // keeps offering, so the pipeline fills and the input stalls.
        idle_pct     = 0;
        stall_pct    = 0;
        hold_request = 1'b1;
        repeat (40)
            send_sample(10'($urandom_range(SAMPLE_MAX)));

        adc_if.valid <= 1'b0;

        // Drain every owed result, then wait on so that a stray extra result would
        // still be caught.
        while (scoreboard.owed_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (scoreboard.errors == 0 && scoreboard.owed_results.size() == 0)
            $display("adc_average_to_servo_compare_test: done, clean");
        else
            $display("adc_average_to_servo_compare_test: done, errors");
        $finish;
    end

    // Watchdog: a correct run takes far less than this.
    initial
    begin
        #1_000_000;
        $display("adc_average_to_servo_compare_test: done, errors");
        $finish;
    end

endmodule
